// ----- hw/rtl/tun_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Shared widths, stage bus types and the output saturation function.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int IN_W          = 16;
    localparam int DIF_W         = IN_W + 1;
    localparam int PRD_W         = 2 * DIF_W;
    localparam int CRS_W         = PRD_W + 1;
    localparam int MAG_W         = CRS_W - 1;
    localparam int HALF_W        = MAG_W / 2;
    localparam int SQ_W          = 2 * MAG_W;
    localparam int SUM_W         = SQ_W + 2;
    localparam int ROOT_W        = SUM_W / 2;
    localparam int OUT_W         = 16;
    localparam int QMAX_W        = 25;
    localparam int FRAC_BITS_DEF = 14;

    typedef struct packed {
        logic                         valid;
        logic [2:0]                   sign;
        logic [2:0][MAG_W-1:0]        mag;
        logic [SUM_W-1:0]             sum;
    } t_crs;

    typedef struct packed {
        logic                         valid;
        logic [2:0]                   sign;
        logic [2:0][MAG_W-1:0]        mag;
        logic [ROOT_W-1:0]            root;
    } t_len;

    function automatic logic [OUT_W-1:0] sat_out(input logic sgn,
                                                 input logic [QMAX_W-1:0] q,
                                                 input logic [QMAX_W-1:0] lim);
        logic [QMAX_W-1:0] v;
        v = (q > lim) ? lim : q;
        if (!sgn && v > QMAX_W'(32767)) begin
            v = QMAX_W'(32767);
        end else if (sgn && v > QMAX_W'(32768)) begin
            v = QMAX_W'(32768);
        end
        return sgn ? OUT_W'(-v[OUT_W-1:0]) : v[OUT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/tun_cross.sv -----
// ----------------------------------------------------------------------------
// Cross product and squared length
// Six stages: edge vectors, partial products, cross components with their
// magnitudes, split squares, assembled squares and the sum of squares.
// ----------------------------------------------------------------------------
module tun_cross
    import tun_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [IN_W-1:0]  i_a [3],
    input  logic signed [IN_W-1:0]  i_b [3],
    input  logic signed [IN_W-1:0]  i_c [3],
    output t_crs                    o_crs
);

    logic [5:0]               r_vld;
    logic signed [DIF_W-1:0]  r_d1 [3];
    logic signed [DIF_W-1:0]  r_d2 [3];
    logic signed [PRD_W-1:0]  r_pa [3];
    logic signed [PRD_W-1:0]  r_pb [3];
    logic [MAG_W-1:0]         r_mag3 [3];
    logic [MAG_W-1:0]         r_mag4 [3];
    logic [MAG_W-1:0]         r_mag5 [3];
    logic [MAG_W-1:0]         r_mag6 [3];
    logic [2:0]               r_sgn3;
    logic [2:0]               r_sgn4;
    logic [2:0]               r_sgn5;
    logic [2:0]               r_sgn6;
    logic [2*HALF_W-1:0]      r_hh [3];
    logic [2*HALF_W-1:0]      r_hl [3];
    logic [2*HALF_W-1:0]      r_ll [3];
    logic [SQ_W-1:0]          r_sq [3];
    logic [SUM_W-1:0]         r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;
        logic signed [CRS_W-1:0] n_cross;
        logic [MAG_W-1:0]        n_mag;

        assign n_cross = CRS_W'(r_pa[g]) - CRS_W'(r_pb[g]);
        assign n_mag   = n_cross[CRS_W-1] ? MAG_W'(-n_cross) : n_cross[MAG_W-1:0];

        always_ff @(posedge i_clk) begin
            r_d1[g]   <= DIF_W'(i_b[g]) - DIF_W'(i_a[g]);
            r_d2[g]   <= DIF_W'(i_c[g]) - DIF_W'(i_a[g]);
            r_pa[g]   <= r_d2[J] * r_d1[K];
            r_pb[g]   <= r_d2[K] * r_d1[J];
            r_sgn3[g] <= n_cross[CRS_W-1];
            r_mag3[g] <= n_mag;
            r_hh[g]   <= r_mag3[g][MAG_W-1:HALF_W] * r_mag3[g][MAG_W-1:HALF_W];
            r_hl[g]   <= r_mag3[g][MAG_W-1:HALF_W] * r_mag3[g][HALF_W-1:0];
            r_ll[g]   <= r_mag3[g][HALF_W-1:0] * r_mag3[g][HALF_W-1:0];
            r_sq[g]   <= (SQ_W'(r_hh[g]) << (2 * HALF_W))
                       + (SQ_W'(r_hl[g]) << (HALF_W + 1))
                       + SQ_W'(r_ll[g]);
            r_mag4[g] <= r_mag3[g];
            r_mag5[g] <= r_mag4[g];
            r_mag6[g] <= r_mag5[g];
            r_sgn4[g] <= r_sgn3[g];
            r_sgn5[g] <= r_sgn4[g];
            r_sgn6[g] <= r_sgn5[g];
        end

        assign o_crs.mag[g] = r_mag6[g];
    end

    always_ff @(posedge i_clk) begin
        r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    assign o_crs.valid = r_vld[5];
    assign o_crs.sign  = r_sgn6;
    assign o_crs.sum   = r_sum;

endmodule

// ----- hw/rtl/tun_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, most significant first, with a running
// remainder; the cross magnitudes and signs travel alongside.
// ----------------------------------------------------------------------------
module tun_sqrt
    import tun_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_crs  i_crs,
    output t_len  o_len
);

    logic [ROOT_W-1:0]      r_vld;
    logic [SUM_W-1:0]       r_rem  [ROOT_W];
    logic [ROOT_W-1:0]      r_root [ROOT_W];
    logic [2:0]             r_sgn  [ROOT_W];
    logic [2:0][MAG_W-1:0]  r_mag  [ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ROOT_W-2:0], i_crs.valid};
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [SUM_W-1:0]      w_rem;
        logic [ROOT_W-1:0]     w_root;
        logic [SUM_W-1:0]      w_trial;
        logic                  w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = i_crs.sum;
            assign w_root = '0;
            always_ff @(posedge i_clk) begin
                r_sgn[k] <= i_crs.sign;
                r_mag[k] <= i_crs.mag;
            end
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            always_ff @(posedge i_clk) begin
                r_sgn[k] <= r_sgn[k-1];
                r_mag[k] <= r_mag[k-1];
            end
        end

        assign w_trial = (SUM_W'(w_root) << (B + 1)) | (SUM_W'(1) << (2 * B));
        assign w_ge    = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? (w_rem - w_trial) : w_rem;
            r_root[k] <= w_root | (ROOT_W'(w_ge) << B);
        end
    end

    assign o_len.valid = r_vld[ROOT_W-1];
    assign o_len.sign  = r_sgn[ROOT_W-1];
    assign o_len.mag   = r_mag[ROOT_W-1];
    assign o_len.root  = r_root[ROOT_W-1];

endmodule

// ----- hw/rtl/tun_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined normalizing divider
// Three restoring divider lanes, one quotient bit per stage, then the
// sign, saturation and degenerate-case output register.
// ----------------------------------------------------------------------------
module tun_div
    import tun_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_len                  i_len,
    output logic                  o_valid,
    output logic [OUT_W-1:0]      o_norm [3],
    output logic                  o_ok
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int REM_W = ROOT_W + 1;

    logic [STEPS-1:0]       r_vld;
    logic [ROOT_W-1:0]      r_len [STEPS];
    logic [2:0]             r_sgn [STEPS];
    logic [REM_W-1:0]       r_rem [STEPS][3];
    logic [STEPS-1:0]       r_q   [STEPS][3];
    logic                   r_out_vld;
    logic                   r_ok;
    logic [OUT_W-1:0]       r_norm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[STEPS-2:0], i_len.valid};
            r_out_vld <= r_vld[STEPS-1];
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_len[k] <= i_len.root;
                r_sgn[k] <= i_len.sign;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_len[k] <= r_len[k-1];
                r_sgn[k] <= r_sgn[k-1];
            end
        end

        for (genvar g = 0; g < 3; g++) begin : g_lane
            logic [REM_W-1:0] w_rem;
            logic [STEPS-1:0] w_q;
            logic [REM_W-1:0] w_div;
            logic             w_ge;

            if (k == 0) begin : g_first
                assign w_rem = REM_W'(i_len.mag[g]);
                assign w_q   = '0;
                assign w_div = REM_W'(i_len.root);
            end else begin : g_next
                assign w_rem = {r_rem[k-1][g][REM_W-2:0], 1'b0};
                assign w_q   = r_q[k-1][g];
                assign w_div = REM_W'(r_len[k-1]);
            end

            assign w_ge = (w_rem >= w_div);

            always_ff @(posedge i_clk) begin
                r_rem[k][g] <= w_ge ? (w_rem - w_div) : w_rem;
                r_q[k][g]   <= {w_q[STEPS-2:0], w_ge};
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_out
        always_ff @(posedge i_clk) begin
            if (r_len[STEPS-1] == '0) begin
                r_norm[g] <= '0;
            end else begin
                r_norm[g] <= sat_out(r_sgn[STEPS-1][g], QMAX_W'(r_q[STEPS-1][g]),
                                     QMAX_W'(1) << FRAC_BITS);
            end
        end
        assign o_norm[g] = r_norm[g];
    end

    always_ff @(posedge i_clk) begin
        r_ok <= (r_len[STEPS-1] != '0);
    end

    assign o_valid = r_out_vld;
    assign o_ok    = r_ok;

endmodule

// ----- hw/rtl/triangle_unit_normal_unit.sv -----
// ----------------------------------------------------------------------------
// Triangle unit normal
// Unit face normal of a triangle given as three Q1.14 vertices.
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge where start is high; busy is
// always low, so one triangle can enter in every cycle. Each triangle gives
// exactly one result, shown for a single cycle with o_valid high. The
// pipeline has six stages for the cross product and sum of squares, one
// stage per root bit in the square root (35 stages), one stage per
// quotient bit in the three divider lanes and one output register.
// Throughput is one triangle per cycle. The receiver cannot stall, so the
// pipeline never holds. A synchronous reset clears all valid bits; triangles
// in flight at that time are dropped. A degenerate triangle gives zero
// outputs with o_normal_ok low.
// ----------------------------------------------------------------------------
module triangle_unit_normal_unit
    import tun_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [IN_W-1:0] i_a_x,
    input  logic signed [IN_W-1:0] i_a_y,
    input  logic signed [IN_W-1:0] i_a_z,
    input  logic signed [IN_W-1:0] i_b_x,
    input  logic signed [IN_W-1:0] i_b_y,
    input  logic signed [IN_W-1:0] i_b_z,
    input  logic signed [IN_W-1:0] i_c_x,
    input  logic signed [IN_W-1:0] i_c_y,
    input  logic signed [IN_W-1:0] i_c_z,
    output logic                   o_valid,
    output logic signed [OUT_W-1:0] o_norm_x,
    output logic signed [OUT_W-1:0] o_norm_y,
    output logic signed [OUT_W-1:0] o_norm_z,
    output logic                   o_normal_ok
);

    logic signed [IN_W-1:0] w_a [3];
    logic signed [IN_W-1:0] w_b [3];
    logic signed [IN_W-1:0] w_c [3];
    logic [OUT_W-1:0]       w_norm [3];
    t_crs                   w_crs;
    t_len                   w_len;

    assign busy = 1'b0;

    assign w_a[0] = i_a_x;
    assign w_a[1] = i_a_y;
    assign w_a[2] = i_a_z;
    assign w_b[0] = i_b_x;
    assign w_b[1] = i_b_y;
    assign w_b[2] = i_b_z;
    assign w_c[0] = i_c_x;
    assign w_c[1] = i_c_y;
    assign w_c[2] = i_c_z;

    tun_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .o_crs   (w_crs)
    );

    tun_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_crs   (w_crs),
        .o_len   (w_len)
    );

    tun_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_len   (w_len),
        .o_valid (o_valid),
        .o_norm  (w_norm),
        .o_ok    (o_normal_ok)
    );

    assign o_norm_x = w_norm[0];
    assign o_norm_y = w_norm[1];
    assign o_norm_z = w_norm[2];

    // A degenerate triangle must report a zero vector.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_normal_ok |-> o_norm_x == '0 && o_norm_y == '0 && o_norm_z == '0)
        else $error("degenerate result with nonzero components");

    // No component of a valid normal may exceed one in magnitude.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_norm_x) <= (32'sd1 <<< FRAC_BITS))
                 && (32'(o_norm_x) >= -(32'sd1 <<< FRAC_BITS))
                 && (32'(o_norm_y) <= (32'sd1 <<< FRAC_BITS))
                 && (32'(o_norm_y) >= -(32'sd1 <<< FRAC_BITS))
                 && (32'(o_norm_z) <= (32'sd1 <<< FRAC_BITS))
                 && (32'(o_norm_z) >= -(32'sd1 <<< FRAC_BITS)))
        else $error("normal component out of range");

    // A nonzero squared length must give a nonzero root.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_crs.valid && w_crs.sum != '0 |-> ##35 w_len.valid && w_len.root != '0)
        else $error("square root lost a nonzero length");

endmodule
